// ----- rtl/sqlct_pkg.sv -----
// ----------------------------------------------------------------------------
// sqlct_pkg
// Types, constants and lookup functions for the command text tokenizer.
// ----------------------------------------------------------------------------
package sqlct_pkg;

   localparam int MAX_WORD_DEF      = 63;
   localparam int MAX_COMMAND_DEF   = 4096;
   localparam int KEYWORD_COUNT_DEF = 33;
   localparam int KW_N              = 33;
   localparam int KW_CHARS          = 10;

   localparam logic [6:0] TOK_INVALID = 7'd0;
   localparam logic [6:0] TOK_IDENT   = 7'd40;
   localparam logic [6:0] TOK_INT     = 7'd41;
   localparam logic [6:0] TOK_FLOAT   = 7'd42;
   localparam logic [6:0] TOK_EQ_EQ   = 7'd57;
   localparam logic [6:0] TOK_TL_EQ   = 7'd58;
   localparam logic [6:0] TOK_GT_EQ   = 7'd59;
   localparam logic [6:0] TOK_LT_EQ   = 7'd60;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_WORD = 2'd1,
      PH_OPER = 2'd2
   } phase_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [6:0]  token_code;
      logic [11:0] token_start;
      logic [5:0]  token_length;
      logic        token_last;
   } rsp_type;

   localparam logic [79:0] KW_TEXT [KW_N] = '{
      80'("create"), 80'("database"), 80'("table"), 80'("alter"), 80'("truncate"),
      80'("add"), 80'("column"), 80'("use"), 80'("drop"), 80'("rename"),
      80'("select"), 80'("from"), 80'("where"), 80'("order"), 80'("by"),
      80'("desc"), 80'("incr"), 80'("update"), 80'("set"), 80'("delete"),
      80'("insert"), 80'("into"), 80'("values"), 80'("show"), 80'("databases"),
      80'("int"), 80'("float"), 80'("text"), 80'("none"), 80'("between"),
      80'("like"), 80'("and"), 80'("or")
   };

   localparam logic [3:0] KW_LEN [KW_N] = '{
      4'd6, 4'd8, 4'd5, 4'd5, 4'd8, 4'd3, 4'd6, 4'd3, 4'd4, 4'd6, 4'd6,
      4'd4, 4'd5, 4'd5, 4'd2, 4'd4, 4'd4, 4'd6, 4'd3, 4'd6, 4'd6, 4'd4,
      4'd6, 4'd4, 4'd9, 4'd3, 4'd5, 4'd4, 4'd4, 4'd7, 4'd4, 4'd3, 4'd2
   };

   // character of keyword k at position p, zero past its end
   function automatic logic [7:0] kw_char(input int k, input logic [3:0] p);
      logic [3:0] idx;
      logic [7:0] c;
      idx = KW_LEN[k] - 4'd1 - p;
      c   = 8'd0;
      if (p < KW_LEN[k]) begin
         c = KW_TEXT[k][{idx, 3'b000} +: 8];
      end
      return c;
   endfunction

   function automatic logic [6:0] single_code(input logic [7:0] b);
      logic [6:0] c;
      case (b)
         8'h28:   c = 7'd50;
         8'h29:   c = 7'd51;
         8'h2a:   c = 7'd52;
         8'h2f:   c = 7'd53;
         8'h25:   c = 7'd54;
         8'h2b:   c = 7'd55;
         8'h2d:   c = 7'd56;
         8'h3e:   c = 7'd61;
         8'h3c:   c = 7'd62;
         8'h5b:   c = 7'd63;
         8'h5d:   c = 7'd64;
         8'h3b:   c = 7'd65;
         8'h2c:   c = 7'd66;
         8'h27:   c = 7'd67;
         8'h3f:   c = 7'd68;
         8'h3d:   c = 7'd69;
         default: c = TOK_INVALID;
      endcase
      return c;
   endfunction

   function automatic logic [6:0] double_code(input logic [7:0] b);
      logic [6:0] c;
      case (b)
         8'h3d:   c = TOK_EQ_EQ;
         8'h7e:   c = TOK_TL_EQ;
         8'h3e:   c = TOK_GT_EQ;
         default: c = TOK_LT_EQ;
      endcase
      return c;
   endfunction

endpackage

// ----- rtl/sql_command_tokenizer.sv -----
// ----------------------------------------------------------------------------
// sql_command_tokenizer
// Byte-serial lexical scanner for command text producing coded tokens.
// ----------------------------------------------------------------------------
// Usage:
//   req channel takes one text byte per beat with a flag on the final byte.
//   rsp channel gives tokens: code, start offset, saturated length and a
//   flag set only on the end token that closes each command.
//   A byte is scanned in the cycle it is accepted; its tokens (zero to
//   three) are registered into a four-entry result queue and leave on rsp
//   in order, one token per cycle while rsp_stall is low.
//   Throughput is one byte per cycle while the queue holds at most one
//   token; a byte that ends a word or operator and is a one-byte token,
//   or a final byte, may add stall cycles while the queue drains one token
//   a cycle. req_stall rises when more than one token is queued.
//   Reset empties the queue and returns the scanner to between tokens at
//   offset zero. While rsp_stall is high the queue head holds and req
//   backs up once more than one token is queued.
// ----------------------------------------------------------------------------
module sql_command_tokenizer #(
   parameter int MAX_WORD      = sqlct_pkg::MAX_WORD_DEF,
   parameter int MAX_COMMAND   = sqlct_pkg::MAX_COMMAND_DEF,
   parameter int KEYWORD_COUNT = sqlct_pkg::KEYWORD_COUNT_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  sqlct_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output sqlct_pkg::rsp_type rsp_data
);
   import sqlct_pkg::*;

   localparam int LW = $clog2(MAX_WORD + 1);
   localparam int PW = $clog2(MAX_COMMAND);
   localparam logic [LW-1:0] LEN_MAX = LW'(MAX_WORD);
   localparam logic [PW-1:0] POS_MAX = PW'(MAX_COMMAND - 1);
   localparam logic [KEYWORD_COUNT-1:0] CAND_ALL = '1;

   phase_type              phase_ff, phase_in;
   logic [KEYWORD_COUNT-1:0] cand_ff, cand_in;
   logic [1:0]             dots_ff, dots_in;
   logic                   num_ff, num_in;
   logic                   ident_ff, ident_in;
   logic [LW-1:0]          len_ff, len_in;
   logic [PW-1:0]          wstart_ff, wstart_in;
   logic [PW-1:0]          pos_ff, pos_in;
   logic [7:0]             pend_ff, pend_in;

   rsp_type                q_ff [4];
   logic [1:0]             wr_ff, rd_ff;
   logic [2:0]             cnt_ff;

   rsp_type                em [3];
   logic [1:0]             n_em;
   logic                   accept, pop;

   function automatic logic [11:0] to_start(input logic [PW-1:0] p);
      logic [PW+11:0] x;
      x = {12'd0, p};
      return x[11:0];
   endfunction

   function automatic logic [5:0] to_len(input logic [LW-1:0] l);
      logic [LW+5:0] x;
      x = {6'd0, l};
      return (x > (LW+6)'(63)) ? 6'd63 : x[5:0];
   endfunction

   function automatic logic [6:0] word_code(
      input logic [KEYWORD_COUNT-1:0] cand, input logic [LW-1:0] l,
      input logic num, input logic [1:0] dots, input logic ident);
      logic [6:0] c;
      c = TOK_IDENT;
      for (int k = KEYWORD_COUNT - 1; k >= 0; k--) begin
         if (cand[k] && ({{(LW-4){1'b0}}, KW_LEN[k]} == l)) begin
            c = 7'(k + 1);
         end
      end
      if (num) begin
         c = (dots == 2'd1) ? TOK_FLOAT : ((dots == 2'd0) ? TOK_INT : TOK_INVALID);
      end else if (!ident) begin
         c = TOK_INVALID;
      end
      return c;
   endfunction

   assign accept    = req_valid && !req_stall;
   assign req_stall = cnt_ff > 3'd1;
   assign rsp_valid = cnt_ff != 3'd0;
   assign rsp_data  = q_ff[rd_ff];
   assign pop       = rsp_valid && !rsp_stall;

   always_comb begin
      logic [7:0] b, lc;
      logic       used, is_dig, is_alp, wc, sp;
      rsp_type    t;
      b      = req_data.in_byte;
      is_dig = (b >= 8'h30) && (b <= 8'h39);
      is_alp = ((b >= 8'h61) && (b <= 8'h7a)) || ((b >= 8'h41) && (b <= 8'h5a));
      wc     = is_dig || is_alp || (b == 8'h5f) || (b == 8'h2e);
      sp     = (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0d));
      lc     = ((b >= 8'h41) && (b <= 8'h5a)) ? b + 8'd32 : b;
      used   = 1'b0;
      phase_in  = phase_ff;
      cand_in   = cand_ff;
      dots_in   = dots_ff;
      num_in    = num_ff;
      ident_in  = ident_ff;
      len_in    = len_ff;
      wstart_in = wstart_ff;
      pos_in    = pos_ff;
      pend_in   = pend_ff;
      n_em      = 2'd0;
      t         = '0;
      for (int i = 0; i < 3; i++) begin
         em[i] = '0;
      end

      if (phase_ff == PH_OPER) begin
         t.token_start = to_start(wstart_ff);
         if (b == 8'h3d) begin
            t.token_code   = double_code(pend_ff);
            t.token_length = 6'd2;
            used = 1'b1;
         end else begin
            t.token_code   = single_code(pend_ff);
            t.token_length = 6'd1;
         end
         em[n_em] = t;
         n_em = n_em + 2'd1;
         phase_in = PH_IDLE;
      end
      if (phase_ff == PH_WORD && !wc) begin
         t.token_code   = word_code(cand_ff, len_ff, num_ff, dots_ff, ident_ff);
         t.token_start  = to_start(wstart_ff);
         t.token_length = to_len(len_ff);
         em[n_em] = t;
         n_em = n_em + 2'd1;
         phase_in = PH_IDLE;
      end
      if (!used) begin
         if (wc) begin
            if (phase_in == PH_IDLE) begin
               phase_in  = PH_WORD;
               wstart_in = pos_ff;
               cand_in   = CAND_ALL;
               dots_in   = 2'd0;
               num_in    = 1'b1;
               ident_in  = is_alp || (b == 8'h5f);
               len_in    = '0;
            end
            for (int k = 0; k < KEYWORD_COUNT; k++) begin
               if ((len_in >= LW'(KW_CHARS)) || (kw_char(k, len_in[3:0]) != lc)) begin
                  cand_in[k] = 1'b0;
               end
            end
            len_in = (len_in >= LEN_MAX) ? LEN_MAX : len_in + LW'(1);
            if (b == 8'h2e) begin
               dots_in = (dots_in == 2'd2) ? 2'd2 : dots_in + 2'd1;
            end
            if (!is_dig && b != 8'h2e) begin
               num_in = 1'b0;
            end
         end else if (sp) begin
            phase_in = phase_in;
         end else if (b == 8'h3d || b == 8'h7e || b == 8'h3c || b == 8'h3e) begin
            phase_in  = PH_OPER;
            pend_in   = b;
            wstart_in = pos_ff;
         end else begin
            t.token_code   = single_code(b);
            t.token_start  = to_start(pos_ff);
            t.token_length = 6'd1;
            em[n_em] = t;
            n_em = n_em + 2'd1;
         end
      end
      pos_in = (pos_ff == POS_MAX) ? '0 : pos_ff + PW'(1);

      if (req_data.in_last) begin
         if (phase_in == PH_WORD) begin
            t.token_code   = word_code(cand_in, len_in, num_in, dots_in, ident_in);
            t.token_start  = to_start(wstart_in);
            t.token_length = to_len(len_in);
            em[n_em] = t;
            n_em = n_em + 2'd1;
         end else if (phase_in == PH_OPER) begin
            t.token_code   = single_code(pend_in);
            t.token_start  = to_start(wstart_in);
            t.token_length = 6'd1;
            em[n_em] = t;
            n_em = n_em + 2'd1;
         end
         t.token_code   = TOK_INVALID;
         t.token_start  = to_start(pos_in);
         t.token_length = 6'd0;
         t.token_last   = 1'b1;
         em[n_em] = t;
         n_em = n_em + 2'd1;
         phase_in  = PH_IDLE;
         cand_in   = CAND_ALL;
         dots_in   = 2'd0;
         num_in    = 1'b1;
         ident_in  = 1'b0;
         len_in    = '0;
         wstart_in = '0;
         pos_in    = '0;
         pend_in   = 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         cand_ff   <= CAND_ALL;
         dots_ff   <= 2'd0;
         num_ff    <= 1'b1;
         ident_ff  <= 1'b0;
         len_ff    <= '0;
         wstart_ff <= '0;
         pos_ff    <= '0;
         pend_ff   <= 8'd0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         cand_ff   <= cand_in;
         dots_ff   <= dots_in;
         num_ff    <= num_in;
         ident_ff  <= ident_in;
         len_ff    <= len_in;
         wstart_ff <= wstart_in;
         pos_ff    <= pos_in;
         pend_ff   <= pend_in;
      end
   end

   // result queue
   always_ff @(posedge clock) begin
      if (accept) begin
         for (int j = 0; j < 3; j++) begin
            if (2'(j) < n_em) begin
               q_ff[wr_ff + 2'(j)] <= em[j];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 2'd0;
         rd_ff  <= 2'd0;
         cnt_ff <= 3'd0;
      end else begin
         if (accept) begin
            wr_ff <= wr_ff + n_em;
         end
         if (pop) begin
            rd_ff <= rd_ff + 2'd1;
         end
         cnt_ff <= cnt_ff + (accept ? {1'b0, n_em} : 3'd0) - (pop ? 3'd1 : 3'd0);
      end
   end

endmodule
